### rtl/aurc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aurc_pkg
// Shared types, constants and helper functions for the receive-notice
// hex payload parser.
// ----------------------------------------------------------------------------
package aurc_pkg;

    localparam int MaxPayload = 512;
    localparam int LenW       = 10;
    localparam int PfxIdxW    = 4;

    localparam logic [7:0] ChPlus  = 8'h2B;
    localparam logic [7:0] ChComma = 8'h2C;
    localparam logic [7:0] ChQuote = 8'h22;
    localparam logic [7:0] Ch0     = 8'h30;
    localparam logic [7:0] Ch9     = 8'h39;
    localparam logic [7:0] ChA     = 8'h41;

    localparam logic [PfxIdxW-1:0] PfxLenNso = 4'd7;
    localparam logic [PfxIdxW-1:0] PfxLenEcs = 4'd8;

    typedef enum logic [1:0] {
        ST_DATA      = 2'd0,
        ST_NO_PREFIX = 2'd1,
        ST_TRUNCATED = 2'd2
    } t_status;

    typedef struct packed {
        logic [7:0] payload_byte;
        logic       payload_last;
        t_status    result_status;
    } t_result;

    function automatic logic [7:0] pfx_char(input logic mode, input logic [PfxIdxW-1:0] idx);
        logic [7:0] ch;
        ch = 8'h00;
        if (mode) begin
            unique case (idx)
                4'd0: ch = 8'h2B;
                4'd1: ch = 8'h45;
                4'd2: ch = 8'h43;
                4'd3: ch = 8'h53;
                4'd4: ch = 8'h4F;
                4'd5: ch = 8'h4E;
                4'd6: ch = 8'h4D;
                4'd7: ch = 8'h49;
                default: ch = 8'h00;
            endcase
        end else begin
            unique case (idx)
                4'd0: ch = 8'h2B;
                4'd1: ch = 8'h4E;
                4'd2: ch = 8'h53;
                4'd3: ch = 8'h4F;
                4'd4: ch = 8'h4E;
                4'd5: ch = 8'h4D;
                4'd6: ch = 8'h49;
                default: ch = 8'h00;
            endcase
        end
        return ch;
    endfunction

    function automatic logic [3:0] hex_nibble(input logic [7:0] c);
        logic [7:0] v;
        if (c > Ch9) begin
            v = c - ChA + 8'd10;
        end else begin
            v = c - Ch0;
        end
        return v[3:0];
    endfunction

endpackage

### rtl/aurc_parse.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aurc_parse
// Line parser state and combinational step logic: prefix search, length
// field, delimiter skip and hex pair decode, with end-of-line reporting.
// ----------------------------------------------------------------------------
module aurc_parse
    import aurc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_take,
    input  logic [7:0] i_char_code,
    input  logic       i_line_end,
    input  logic       i_mode,
    output logic       o_push,
    output t_result    o_result
);

    typedef enum logic [2:0] {
        PH_SEARCH = 3'd0,
        PH_COMMA  = 3'd1,
        PH_LENGTH = 3'd2,
        PH_DELIM  = 3'd3,
        PH_HEX    = 3'd4,
        PH_DONE   = 3'd5
    } t_phase;

    t_phase              r_phase,   n_phase;
    logic [PfxIdxW-1:0]  r_pfx_idx, n_pfx_idx;
    logic [LenW-1:0]     r_len,     n_len;
    logic [LenW-1:0]     r_emitted, n_emitted;
    logic [3:0]          r_hi_nib,  n_hi_nib;
    logic                r_pend,    n_pend;

    logic [7:0]          delim;
    logic [PfxIdxW-1:0]  pfx_len;
    logic                is_digit;
    logic [LenW+3:0]     len_acc;
    logic [3:0]          nib;
    logic                byte_out;
    logic                byte_last;
    logic [7:0]          byte_val;

    always_comb begin
        delim     = i_mode ? ChQuote : ChComma;
        pfx_len   = i_mode ? PfxLenEcs : PfxLenNso;
        is_digit  = (i_char_code >= Ch0) && (i_char_code <= Ch9);
        len_acc   = ({4'd0, r_len} << 3) + ({4'd0, r_len} << 1)
                  + {6'd0, i_char_code - Ch0};
        nib       = hex_nibble(i_char_code);
        n_phase   = r_phase;
        n_pfx_idx = r_pfx_idx;
        n_len     = r_len;
        n_emitted = r_emitted;
        n_hi_nib  = r_hi_nib;
        n_pend    = r_pend;
        byte_out  = 1'b0;
        byte_last = 1'b0;
        byte_val  = {r_hi_nib, nib};

        unique case (r_phase)
            PH_SEARCH: begin
                if ((r_pfx_idx < pfx_len) && (i_char_code == pfx_char(i_mode, r_pfx_idx))) begin
                    if (r_pfx_idx + 4'd1 == pfx_len) begin
                        n_phase   = PH_COMMA;
                        n_pfx_idx = '0;
                    end else begin
                        n_pfx_idx = r_pfx_idx + 4'd1;
                    end
                end else begin
                    n_pfx_idx = (i_char_code == ChPlus) ? 4'd1 : 4'd0;
                end
            end
            PH_COMMA: begin
                if (i_char_code == ChComma) begin
                    n_phase = PH_LENGTH;
                    n_len   = '0;
                end
            end
            PH_LENGTH: begin
                if (is_digit) begin
                    n_len = (len_acc > (LenW+4)'(MaxPayload)) ? LenW'(MaxPayload)
                                                              : len_acc[LenW-1:0];
                end else if (r_len == '0) begin
                    n_phase = PH_DONE;
                end else if (i_char_code == delim) begin
                    n_phase = PH_HEX;
                    n_pend  = 1'b0;
                end else begin
                    n_phase = PH_DELIM;
                end
            end
            PH_DELIM: begin
                if (i_char_code == delim) begin
                    n_phase = PH_HEX;
                    n_pend  = 1'b0;
                end
            end
            PH_HEX: begin
                if (!r_pend) begin
                    n_hi_nib = nib;
                    n_pend   = 1'b1;
                end else begin
                    n_pend    = 1'b0;
                    n_emitted = r_emitted + 1'b1;
                    byte_out  = 1'b1;
                    if (n_emitted >= r_len) begin
                        byte_last = 1'b1;
                        n_phase   = PH_DONE;
                    end
                end
            end
            default: begin
            end
        endcase

        o_push                 = byte_out;
        o_result.payload_byte  = byte_val;
        o_result.payload_last  = byte_last;
        o_result.result_status = ST_DATA;

        if (i_line_end) begin
            if (byte_out && !byte_last) begin
                o_result.payload_byte  = 8'd0;
                o_result.payload_last  = 1'b1;
                o_result.result_status = ST_TRUNCATED;
            end else if (!byte_out) begin
                o_result.payload_byte  = 8'd0;
                o_result.payload_last  = 1'b1;
                if (n_phase == PH_SEARCH) begin
                    o_push                 = 1'b1;
                    o_result.result_status = ST_NO_PREFIX;
                end else if ((n_phase == PH_DONE) ||
                             ((n_phase == PH_LENGTH) && (n_len == '0))) begin
                    o_push = 1'b0;
                end else begin
                    o_push                 = 1'b1;
                    o_result.result_status = ST_TRUNCATED;
                end
            end
            n_phase   = PH_SEARCH;
            n_pfx_idx = '0;
            n_len     = '0;
            n_emitted = '0;
            n_hi_nib  = '0;
            n_pend    = 1'b0;
        end

        if (!i_take) begin
            o_push = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_SEARCH;
            r_pfx_idx <= '0;
            r_len     <= '0;
            r_emitted <= '0;
            r_hi_nib  <= '0;
            r_pend    <= 1'b0;
        end else if (i_take) begin
            r_phase   <= n_phase;
            r_pfx_idx <= n_pfx_idx;
            r_len     <= n_len;
            r_emitted <= n_emitted;
            r_hi_nib  <= n_hi_nib;
            r_pend    <= n_pend;
        end
    end

endmodule

### rtl/aurc_out_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aurc_out_fifo
// Two-entry result queue; decouples the parser from the downstream stall.
// ----------------------------------------------------------------------------
module aurc_out_fifo
    import aurc_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_result i_data,
    output logic    o_full,
    output logic    o_valid,
    input  logic    i_pop,
    output t_result o_data
);

    t_result     r_mem [2];
    logic        r_wr_ptr, n_wr_ptr;
    logic        r_rd_ptr, n_rd_ptr;
    logic [1:0]  r_count,  n_count;
    logic        do_pop;

    always_comb begin
        do_pop   = i_pop && (r_count != 2'd0);
        n_wr_ptr = i_push ? ~r_wr_ptr : r_wr_ptr;
        n_rd_ptr = do_pop ? ~r_rd_ptr : r_rd_ptr;
        n_count  = r_count + {1'b0, i_push} - {1'b0, do_pop};
        o_full   = (r_count == 2'd2);
        o_valid  = (r_count != 2'd0);
        o_data   = r_mem[r_rd_ptr];
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule

### rtl/at_urc_hex_payload_parser_top.sv
`timescale 1ns / 1ps
// Takes one character word per cycle with no gaps required; each word gives
// at most one result word, written into a two-entry output queue at the edge
// that accepts the character and offered once it reaches the queue head. The input stalls
// only while that queue is full. Configuration (notice_mode) is a single-bit
// register written through i_cfg_wr_en.
// ----------------------------------------------------------------------------
// at_urc_hex_payload_parser_top
// Receive-notice parser: finds the notice prefix, reads the payload length
// and decodes the hex payload into bytes, reporting missing or short lines.
// ----------------------------------------------------------------------------
module at_urc_hex_payload_parser_top
    import aurc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_wr_en,
    input  logic       i_cfg_wr_data,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [7:0] i_char_code,
    input  logic       i_line_end,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [7:0] o_payload_byte,
    output logic       o_payload_last,
    output logic [1:0] o_result_status
);

    logic    r_notice_mode;
    logic    take;
    logic    push;
    logic    full;
    t_result res;
    t_result head;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_notice_mode <= 1'b0;
        end else if (i_cfg_wr_en) begin
            r_notice_mode <= i_cfg_wr_data;
        end
    end

    assign o_in_ready = !full;
    assign take       = i_in_valid && !full;

    aurc_parse u_parse (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_take      (take),
        .i_char_code (i_char_code),
        .i_line_end  (i_line_end),
        .i_mode      (r_notice_mode),
        .o_push      (push),
        .o_result    (res)
    );

    aurc_out_fifo u_out_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (res),
        .o_full  (full),
        .o_valid (o_out_valid),
        .i_pop   (i_out_ready),
        .o_data  (head)
    );

    assign o_payload_byte  = head.payload_byte;
    assign o_payload_last  = head.payload_last;
    assign o_result_status = head.result_status;

endmodule
